FILE: rtl/ltrf_pkg.sv
// ----------------------------------------------------------------------------
// ltrf_pkg
// Types and constants shared by the longest tandem repeat finder.
// ----------------------------------------------------------------------------
package ltrf_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int MAX_TEXT        = 1048576;

	localparam int SYM_W     = 8;
	localparam int LEN_W     = 5;
	localparam int POS_W     = 21;
	localparam int START_W   = 20;
	localparam int COUNT_W   = 21;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;
	localparam int PAT_W     = 128;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LEN = 2'd0,
		REG_PATTERN_LO  = 2'd1,
		REG_PATTERN_HI  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
	} item_t;

	typedef struct packed {
		logic               found;
		logic [START_W-1:0] run_start;
		logic [COUNT_W-1:0] run_repeats;
		logic [COUNT_W-1:0] run_chars;
		logic               overflowed;
	} result_t;

	typedef struct packed {
		logic               active;
		logic               hit;
		logic [START_W-1:0] start;
	} scan_t;

endpackage

FILE: rtl/ltrf_scan.sv
// ----------------------------------------------------------------------------
// ltrf_scan
// Byte window and position counter; compares the window against the pattern.
// ----------------------------------------------------------------------------
module ltrf_scan #(
	parameter int MAX_PATTERN = ltrf_pkg::MAX_PATTERN_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic                           clear,
	input  logic [ltrf_pkg::SYM_W-1:0]     symbol,
	input  logic [ltrf_pkg::LEN_W-1:0]     len,
	input  logic [MAX_PATTERN*8-1:0]       pattern,
	output ltrf_pkg::scan_t                scan
);
	import ltrf_pkg::*;

	localparam int IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [SYM_W-1:0] win_q    [MAX_PATTERN];
	logic [SYM_W-1:0] win_next [MAX_PATTERN];
	logic [POS_W-1:0] pos_q;
	logic [MAX_PATTERN-1:0] byte_ok;
	logic [LEN_W-1:0] idx [MAX_PATTERN];
	logic [POS_W-1:0] start_full;

	always_comb begin
		win_next[0] = symbol;
		for (int i = 1; i < MAX_PATTERN; i++) begin
			win_next[i] = win_q[i-1];
		end
	end

	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++) begin
			idx[k] = len - LEN_W'(1) - LEN_W'(k);
			if (LEN_W'(k) < len) begin
				byte_ok[k] = (win_next[idx[k][IdxW-1:0]] == pattern[k*8 +: 8]);
			end else begin
				byte_ok[k] = 1'b1;
			end
		end
	end

	assign start_full  = pos_q + POS_W'(1) - POS_W'(len);
	assign scan.active = (pos_q < POS_W'(MAX_TEXT));
	assign scan.hit    = (&byte_ok) && (pos_q + POS_W'(1) >= POS_W'(len));
	assign scan.start  = start_full[START_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			for (int i = 0; i < MAX_PATTERN; i++) begin
				win_q[i] <= '0;
			end
		end else if (step && clear) begin
			pos_q <= '0;
			for (int i = 0; i < MAX_PATTERN; i++) begin
				win_q[i] <= '0;
			end
		end else if (step && scan.active) begin
			pos_q <= pos_q + POS_W'(1);
			for (int i = 0; i < MAX_PATTERN; i++) begin
				win_q[i] <= win_next[i];
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_clear_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(step && clear) |=> (pos_q == '0))
		else $error("position not cleared after the final byte");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MAX_TEXT))
		else $error("position counter passed its saturation point");
`endif

endmodule

FILE: rtl/ltrf_run.sv
// ----------------------------------------------------------------------------
// ltrf_run
// Run tracking: current and longest run of back-to-back occurrences.
// ----------------------------------------------------------------------------
module ltrf_run (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       clear,
	input  logic [ltrf_pkg::LEN_W-1:0] len,
	input  ltrf_pkg::scan_t            scan,
	output ltrf_pkg::result_t          result
);
	import ltrf_pkg::*;

	logic [START_W-1:0] prev_start_q, prev_start_n;
	logic               prev_valid_q, prev_valid_n;
	logic [COUNT_W-1:0] cur_count_q, cur_count_n;
	logic [START_W-1:0] cur_start_q, cur_start_n;
	logic [COUNT_W-1:0] best_count_q, best_count_n;
	logic [START_W-1:0] best_start_q, best_start_n;
	logic               ovf_q, ovf_n;
	logic               contig;
	logic [COUNT_W+LEN_W-1:0] chars_full;

	assign contig = prev_valid_q &&
		({1'b0, scan.start} == ({1'b0, prev_start_q} + (START_W+1)'(len)));

	always_comb begin
		prev_start_n = prev_start_q;
		prev_valid_n = prev_valid_q;
		cur_count_n  = cur_count_q;
		cur_start_n  = cur_start_q;
		best_count_n = best_count_q;
		best_start_n = best_start_q;
		ovf_n        = ovf_q;
		if (!scan.active) begin
			ovf_n = 1'b1;
		end else if (scan.hit) begin
			if (contig) begin
				cur_count_n = cur_count_q + COUNT_W'(1);
			end else begin
				cur_count_n = COUNT_W'(1);
				cur_start_n = scan.start;
			end
			if (cur_count_n > best_count_q) begin
				best_count_n = cur_count_n;
				best_start_n = cur_start_n;
			end
			prev_start_n = scan.start;
			prev_valid_n = 1'b1;
		end
	end

	assign chars_full = {{LEN_W{1'b0}}, best_count_n} * {{COUNT_W{1'b0}}, len};

	always_comb begin
		result            = '0;
		result.overflowed = ovf_n;
		if (prev_valid_n) begin
			result.found       = 1'b1;
			result.run_start   = best_start_n;
			result.run_repeats = best_count_n;
			result.run_chars   = chars_full[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_start_q <= '0;
			prev_valid_q <= 1'b0;
			cur_count_q  <= '0;
			cur_start_q  <= '0;
			best_count_q <= '0;
			best_start_q <= '0;
			ovf_q        <= 1'b0;
		end else if (step && clear) begin
			prev_start_q <= '0;
			prev_valid_q <= 1'b0;
			cur_count_q  <= '0;
			cur_start_q  <= '0;
			best_count_q <= '0;
			best_start_q <= '0;
			ovf_q        <= 1'b0;
		end else if (step) begin
			prev_start_q <= prev_start_n;
			prev_valid_q <= prev_valid_n;
			cur_count_q  <= cur_count_n;
			cur_start_q  <= cur_start_n;
			best_count_q <= best_count_n;
			best_start_q <= best_start_n;
			ovf_q        <= ovf_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_best_covers_cur: assert property (@(posedge clk) disable iff (!arst_n)
		best_count_q >= cur_count_q)
		else $error("current run longer than the recorded best run");

	a_found_has_run: assert property (@(posedge clk) disable iff (!arst_n)
		prev_valid_q == (best_count_q != '0))
		else $error("occurrence flag disagrees with the best run count");
`endif

endmodule

FILE: rtl/longest_tandem_repeat_finder.sv
// ----------------------------------------------------------------------------
// longest_tandem_repeat_finder
// Streams text bytes, finds pattern occurrences and reports the longest run
// of back-to-back copies when the final byte arrives.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_ready     item_t (symbol, last)
// result    out        result_valid / result_ready result_t
// cfg       in         cfg_write                   cfg_index, cfg_data
//
// Each beat is registered on entry and then processed by the window compare and
// run update; one byte per cycle is sustained while the input is not stalled.
// A result is registered in the output register when its final byte leaves the
// input register. Only a final byte waits while the output register is still full.
// Reset clears all run state; the final byte of each text clears it as well.
// ----------------------------------------------------------------------------
module longest_tandem_repeat_finder #(
	parameter int MAX_PATTERN = ltrf_pkg::MAX_PATTERN_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  ltrf_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output ltrf_pkg::result_t              result,
	input  logic                           cfg_write,
	input  logic [ltrf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ltrf_pkg::CFG_W-1:0]     cfg_data
);
	import ltrf_pkg::*;

	logic [LEN_W-1:0] plen_q;
	logic [CFG_W-1:0] pat_lo_q;
	logic [CFG_W-1:0] pat_hi_q;
	logic [PAT_W-1:0] pat_all;
	logic [LEN_W-1:0] len_used;

	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	scan_t   scan;
	result_t result_next;
	result_t result_q;
	logic    result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q   <= LEN_W'(1);
			pat_lo_q <= '0;
			pat_hi_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PATTERN_LEN: plen_q   <= cfg_data[LEN_W-1:0];
				REG_PATTERN_LO:  pat_lo_q <= cfg_data;
				REG_PATTERN_HI:  pat_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pat_all = {pat_hi_q, pat_lo_q};

	always_comb begin
		if (plen_q == '0) begin
			len_used = LEN_W'(1);
		end else if (plen_q > LEN_W'(MAX_PATTERN)) begin
			len_used = LEN_W'(MAX_PATTERN);
		end else begin
			len_used = plen_q;
		end
	end

	assign advance    = valid_s1 && (!item_s1.last || !result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	ltrf_scan #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.clear   (item_s1.last),
		.symbol  (item_s1.symbol),
		.len     (len_used),
		.pattern (pat_all[MAX_PATTERN*8-1:0]),
		.scan    (scan)
	);

	ltrf_run u_run (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.clear  (item_s1.last),
		.len    (len_used),
		.scan   (scan),
		.result (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && item_s1.last) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last) begin
			result_q <= result_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef NO_ASSERTIONS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (valid_s1 && item_s1.last && result_valid_q && !result_ready))
		else $error("input stalled without a blocked final byte");

	a_found_repeats: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.found) |-> (result.run_repeats != '0))
		else $error("result reports an occurrence with an empty run");
`endif

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for longest_tandem_repeat_finder. A few directed texts
// cover reset settings, clamped pattern lengths, overlaps, ties and a pattern
// change inside a text. Random texts built from pattern copies, fragments and
// noise then run under many pattern settings, with random idle cycles on both
// channels. A scoreboard predicts every report and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
	import ltrf_pkg::*;

	localparam int CYCLE_LIMIT   = 400_000;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_ITEMS  = 1900;

	class tandem_run_scoreboard;
		logic [LEN_W-1:0] len_reg;
		logic [CFG_W-1:0] pat_lo_reg;
		logic [CFG_W-1:0] pat_hi_reg;
		logic [SYM_W-1:0] window [16];
		int unsigned      byte_count;
		int unsigned      last_occ_start;
		bit               last_occ_seen;
		int unsigned      run_count;
		int unsigned      run_begin;
		int unsigned      best_count;
		int unsigned      best_begin;
		bit               past_limit;
		result_t          expected_reports [$];
		int               errors;
		int               reports_checked;
		int               found_reports;
		int               overflow_reports;

		function new();
			len_reg = 5'd1;
			pat_lo_reg = '0;
			pat_hi_reg = '0;
			errors = 0;
			reports_checked = 0;
			found_reports = 0;
			overflow_reports = 0;
			clear_text();
		endfunction

		function void clear_text();
			foreach (window[i]) window[i] = '0;
			byte_count = 0;
			last_occ_start = 0;
			last_occ_seen = 1'b0;
			run_count = 0;
			run_begin = 0;
			best_count = 0;
			best_begin = 0;
			past_limit = 1'b0;
		endfunction

		function void write_reg(cfg_reg_t index, logic [CFG_W-1:0] data);
			case (index)
				REG_PATTERN_LEN: len_reg = data[LEN_W-1:0];
				REG_PATTERN_LO: pat_lo_reg = data;
				REG_PATTERN_HI: pat_hi_reg = data;
				default: ;
			endcase
		endfunction

		function int unsigned active_len();
			if (len_reg == 0) return 1;
			if (len_reg > MAX_PATTERN_DEF) return MAX_PATTERN_DEF;
			return len_reg;
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		function void note_beat(item_t beat);
			logic [PAT_W-1:0] pattern;
			int unsigned      plen;
			int unsigned      occ_start;
			bit               hit;
			result_t          report;
			plen = active_len();
			pattern = {pat_hi_reg, pat_lo_reg};
			if (byte_count >= MAX_TEXT) begin
				past_limit = 1'b1;
			end else begin
				for (int i = 15; i > 0; i--) window[i] = window[i - 1];
				window[0] = beat.symbol;
				hit = (byte_count + 1 >= plen);
				for (int k = 0; k < plen; k++) begin
					if (window[plen - 1 - k] != pattern[8 * k +: 8]) hit = 1'b0;
				end
				if (hit) begin
					occ_start = byte_count + 1 - plen;
					if (last_occ_seen && occ_start == last_occ_start + plen) begin
						run_count++;
					end else begin
						run_count = 1;
						run_begin = occ_start;
					end
					if (run_count > best_count) begin
						best_count = run_count;
						best_begin = run_begin;
					end
					last_occ_start = occ_start;
					last_occ_seen = 1'b1;
				end
				byte_count++;
			end
			if (beat.last) begin
				report = '0;
				if (last_occ_seen) begin
					report.found = 1'b1;
					report.run_start = START_W'(best_begin);
					report.run_repeats = COUNT_W'(best_count);
					report.run_chars = COUNT_W'(best_count * plen);
				end
				report.overflowed = past_limit;
				expected_reports = {expected_reports, report};
				clear_text();
			end
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_reports.size() == 0) begin
				$error("result beat with no report expected: %h", got);
				errors++;
				return;
			end
			want = expected_reports.pop_front();
			reports_checked++;
			compare_field("found", want.found, got.found);
			compare_field("run_start", want.run_start, got.run_start);
			compare_field("run_repeats", want.run_repeats, got.run_repeats);
			compare_field("run_chars", want.run_chars, got.run_chars);
			compare_field("overflowed", want.overflowed, got.overflowed);
			if (want.found) found_reports++;
			if (want.overflowed) overflow_reports++;
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_ready;
	item_t                item;
	logic                 result_valid;
	logic                 result_ready;
	result_t              result;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	tandem_run_scoreboard runs = new();

	int               send_gap_max = 8;
	int               take_gap_max = 8;
	int               take_hold = 0;
	int unsigned      cycle_count;
	int               items_sent = 0;
	logic [SYM_W-1:0] pat_bytes [16];
	int               pat_span = 1;
	logic [SYM_W-1:0] alphabet [3];
	logic [SYM_W-1:0] text_q [$];

	longest_tandem_repeat_finder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
			runs.pending());
		$display("status: fail");
		$finish;
	end

	initial begin
		int gap;
		result_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (take_hold > 0) begin
				gap = take_hold;
				take_hold = 0;
			end else begin
				gap = $urandom_range(0, take_gap_max);
			end
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			runs.check_result(result);
			@(negedge clk);
		end
	end

	task automatic send_beat(logic [SYM_W-1:0] symbol, logic last);
		int    gap;
		item_t beat;
		beat.symbol = symbol;
		beat.last = last;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= beat;
		do @(posedge clk); while (!item_ready);
		runs.note_beat(beat);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(bit close);
		foreach (text_q[i]) send_beat(text_q[i], close && i == text_q.size() - 1);
	endtask

	// Lets the block finish every byte it holds before registers change.
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (runs.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic configure(logic [LEN_W-1:0] len, logic [PAT_W-1:0] pattern);
		cfg_reg_t         index;
		logic [CFG_W-1:0] value [3];
		value[0] = CFG_W'(len);
		value[1] = pattern[CFG_W-1:0];
		value[2] = pattern[PAT_W-1:CFG_W];
		index = REG_PATTERN_LEN;
		for (int r = 0; r < 3; r++) begin
			cfg_write <= 1'b1;
			cfg_index <= index;
			cfg_data <= value[r];
			@(posedge clk);
			runs.write_reg(index, value[r]);
			@(negedge clk);
			index = index.next();
		end
		cfg_write <= 1'b0;
	endtask

	task automatic pick_pattern();
		logic [PAT_W-1:0] pattern;
		logic [LEN_W-1:0] len_raw;
		int               mode;
		foreach (alphabet[i]) alphabet[i] = SYM_W'($urandom);
		case ($urandom_range(0, 9))
			0: len_raw = 5'd0;
			1: len_raw = LEN_W'($urandom_range(17, 31));
			2, 3: len_raw = LEN_W'($urandom_range(7, 16));
			default: len_raw = LEN_W'($urandom_range(1, 6));
		endcase
		mode = $urandom_range(0, 3);
		for (int k = 0; k < 16; k++) begin
			if (mode == 0) pat_bytes[k] = SYM_W'($urandom);
			else if (mode == 1) pat_bytes[k] = alphabet[0];
			else pat_bytes[k] = alphabet[$urandom_range(0, 2)];
			pattern[8 * k +: 8] = pat_bytes[k];
		end
		configure(len_raw, pattern);
		pat_span = runs.active_len();
	endtask

	function automatic void build_text(int max_bytes);
		int target;
		int choice;
		int cut;
		text_q.delete();
		target = $urandom_range(1, max_bytes);
		while (text_q.size() < target) begin
			choice = $urandom_range(0, 9);
			if (choice < 5) begin
				repeat ($urandom_range(1, 4)) begin
					for (int k = 0; k < pat_span; k++) text_q = {text_q, pat_bytes[k]};
				end
			end else if (choice < 7) begin
				cut = $urandom_range(1, pat_span);
				for (int k = 0; k < cut; k++) text_q = {text_q, pat_bytes[k]};
			end else if (choice < 9) begin
				text_q = {text_q, alphabet[$urandom_range(0, 2)]};
			end else begin
				text_q = {text_q, SYM_W'($urandom)};
			end
		end
	endfunction

	initial begin
		int random_goal;
		int phase;
		int texts;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_write = 1'b0;
		cfg_index = REG_PATTERN_LEN;
		cfg_data = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Settings straight out of reset: one-byte pattern of zero.
		text_q = '{8'h00};
		send_text(1);

		// A zero length acts as one; two equal single runs tie.
		wait_idle();
		configure(5'd0, PAT_W'(8'hFF));
		text_q = '{8'hFF, 8'h00, 8'hFF};
		send_text(1);

		// Overlapping occurrences of a self-similar pattern.
		wait_idle();
		configure(5'd2, PAT_W'(16'h6161));
		text_q = '{8'h61, 8'h61, 8'h61, 8'h61, 8'h61};
		send_text(1);

		// Pattern changed between two bytes of the same text.
		text_q = '{8'h61, 8'h61};
		send_text(0);
		wait_idle();
		configure(5'd1, PAT_W'(8'h62));
		text_q = '{8'h62, 8'h62};
		send_text(1);

		// The largest length value clamps to the full sixteen bytes.
		wait_idle();
		configure(5'd31, {64'h0, 64'hFFFF_FFFF_FFFF_FFFF});
		text_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_text(1);

		random_goal = items_sent + RANDOM_ITEMS;
		phase = 0;
		while (items_sent < random_goal) begin
			wait_idle();
			pick_pattern();
			case ($urandom_range(0, 3))
				0: begin send_gap_max = 0; take_gap_max = 0; end
				1: begin send_gap_max = 8; take_gap_max = 0; end
				2: begin send_gap_max = 0; take_gap_max = 8; end
				default: begin send_gap_max = 8; take_gap_max = 8; end
			endcase
			if (phase == 0) begin
				// Receiver holds off while short texts keep coming back to back.
				take_hold = 300;
				send_gap_max = 0;
				repeat (12) begin
					build_text(6);
					send_text(1);
				end
			end else begin
				texts = $urandom_range(1, 6);
				repeat (texts) begin
					build_text(40);
					send_text(1);
				end
				if ($urandom_range(0, 4) == 0) begin
					build_text(20);
					send_text(0);
				end
			end
			phase++;
		end
		text_q = '{8'h5A};
		send_text(1);

		wait_idle();
		repeat (8) @(posedge clk);
		$display("%0d bytes over %0d random settings, with stalls on both sides",
			items_sent, phase);
		$display("%0d reports checked, %0d found, %0d overflowed",
			runs.reports_checked, runs.found_reports, runs.overflow_reports);
		if (runs.errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule
